[sv/cartridge_image_stream_decoder_unit_macros.svh]
// Assertion helpers used by the decoder top level.
`ifndef CARTRIDGE_IMAGE_STREAM_DECODER_UNIT_MACROS_SVH
`define CARTRIDGE_IMAGE_STREAM_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define CISD_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define CISD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

[sv/cisd_pkg.sv]
package cisd_pkg;

  localparam int unsigned STORE_WORDS_MAX = 65536;
  localparam int unsigned MAX_MAPPINGS = 16;
  localparam int unsigned MAP_CNT_W = $clog2(MAX_MAPPINGS + 1);

  localparam logic [16:0] CAP_LIMIT =
    (STORE_WORDS_MAX < 65536) ? 17'(STORE_WORDS_MAX) : 17'h10000;
  localparam logic [MAP_CNT_W-1:0] MAP_LIMIT = MAP_CNT_W'(MAX_MAPPINGS);

  localparam logic [7:0] MAGIC_A = 8'hA8;
  localparam logic [7:0] MAGIC_B = 8'h41;
  localparam logic [7:0] MAGIC_C = 8'h61;
  localparam logic [7:0] COMPL_MASK = 8'hFF;
  localparam logic [15:0] BUS_MIN = 16'h2000;
  localparam logic [16:0] PAGE_WORDS = 17'h100;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_BYTES = 2'd2;

  localparam logic [15:0] STAGE_BASE_RST = 16'h0000;
  localparam logic [16:0] STORE_WORDS_RST = 17'h10000;
  localparam logic [17:0] EXPECTED_BYTES_RST = 18'h00000;

  typedef enum logic [1:0] {FMT_UNKNOWN, FMT_FLAT, FMT_HDR, FMT_REJECTED} fmt_t;
  typedef enum logic [1:0] {PH_ADDR, PH_DATA, PH_CRC} phase_t;
  typedef enum logic [1:0] {ST_OK, ST_TOOBIG, ST_REJECTED, ST_TRUNC} status_t;

  typedef struct packed {
    logic [15:0] stage_base;
    logic [16:0] store_words;
    logic [17:0] expected_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic        seg_valid;
    logic [15:0] seg_bus_addr;
    logic [15:0] seg_stage_start;
    logic [15:0] seg_words;
    logic        done_res;
    status_t     status;
  } result_t;

endpackage

[sv/cisd_in_stage.sv]
module cisd_in_stage
  import cisd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] data_byte,
  input  logic     last_byte,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte <= data_byte;
      item.last_byte <= last_byte;
    end
  end

endmodule

[sv/cisd_core.sv]
module cisd_core
  import cisd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     fire,
  input  in_item_t item,
  output result_t  res
);

  fmt_t                 fmt, fmt_next;
  phase_t               phase, phase_next;
  status_t              sticky, sticky_next;
  logic [7:0]           probe0, probe0_next;
  logic [7:0]           probe1, probe1_next;
  logic [1:0]           probe_count, probe_count_next;
  logic [7:0]           seg_total, seg_total_next;
  logic [7:0]           seg_done, seg_done_next;
  logic [7:0]           range_low, range_low_next;
  logic                 range_cnt, range_cnt_next;
  logic [15:0]          words_rem, words_rem_next;
  logic [16:0]          seg_addr, seg_addr_next;
  logic                 held_flag, held_flag_next;
  logic [7:0]           held_byte, held_byte_next;
  logic                 crc_cnt, crc_cnt_next;
  logic [16:0]          wp, wp_next;
  logic [17:0]          byte_total, byte_total_next;
  logic [MAP_CNT_W-1:0] maps, maps_next;

  logic [16:0] cap;
  logic [7:0]  b;
  logic        hdr_ok;
  logic [15:0] lo;
  logic [16:0] hi;
  logic [16:0] words;

  assign cap = (cfg.store_words > CAP_LIMIT) ? CAP_LIMIT : cfg.store_words;
  assign b = item.data_byte;

  always_comb begin
    fmt_next = fmt;
    phase_next = phase;
    sticky_next = sticky;
    probe0_next = probe0;
    probe1_next = probe1;
    probe_count_next = probe_count;
    seg_total_next = seg_total;
    seg_done_next = seg_done;
    range_low_next = range_low;
    range_cnt_next = range_cnt;
    words_rem_next = words_rem;
    seg_addr_next = seg_addr;
    held_flag_next = held_flag;
    held_byte_next = held_byte;
    crc_cnt_next = crc_cnt;
    wp_next = wp;
    byte_total_next = byte_total;
    maps_next = maps;
    hdr_ok = 1'b0;
    lo = {range_low, 8'h00};
    hi = {1'b0, b, 8'h00} + PAGE_WORDS;
    words = hi - {1'b0, lo};
    res = '0;
    res.status = ST_OK;

    if (byte_total == '0 && fmt == FMT_UNKNOWN && probe_count == 2'd0) begin
      wp_next = {1'b0, cfg.stage_base};
      if ({1'b0, cfg.expected_bytes[17:1]} > cap) begin
        fmt_next = FMT_REJECTED;
        sticky_next = ST_TOOBIG;
      end
    end
    if (byte_total != '1) begin
      byte_total_next = byte_total + 18'd1;
    end

    unique case (fmt_next)
      FMT_UNKNOWN: begin
        probe_count_next = probe_count + 2'd1;
        if (probe_count == 2'd0) begin
          probe0_next = b;
        end else if (probe_count == 2'd1) begin
          probe1_next = b;
        end else begin
          hdr_ok = (probe0 == MAGIC_A || probe0 == MAGIC_B || probe0 == MAGIC_C) &&
                   probe1 != 8'h00 && (probe1 ^ b) == COMPL_MASK;
          if (hdr_ok) begin
            fmt_next = FMT_HDR;
            seg_total_next = probe1;
            seg_done_next = 8'h00;
            phase_next = PH_ADDR;
            range_cnt_next = 1'b0;
            maps_next = '0;
          end else begin
            fmt_next = FMT_FLAT;
            held_flag_next = 1'b0;
            if (cfg.expected_bytes != '0 &&
                ({2'b00, cfg.stage_base} + {1'b0, cfg.expected_bytes[17:1]}) >
                {1'b0, cap}) begin
              fmt_next = FMT_REJECTED;
              sticky_next = ST_TOOBIG;
            end else if (wp < cap) begin
              res.write_valid = 1'b1;
              res.write_addr = wp[15:0];
              res.write_data = {probe0, probe1};
              wp_next = wp + 17'd1;
              held_byte_next = b;
              held_flag_next = 1'b1;
            end else begin
              fmt_next = FMT_REJECTED;
              sticky_next = ST_TOOBIG;
            end
          end
        end
      end
      FMT_FLAT: begin
        if (!held_flag) begin
          held_byte_next = b;
          held_flag_next = 1'b1;
        end else begin
          held_flag_next = 1'b0;
          if (wp < cap) begin
            res.write_valid = 1'b1;
            res.write_addr = wp[15:0];
            res.write_data = {held_byte, b};
            wp_next = wp + 17'd1;
          end else begin
            fmt_next = FMT_REJECTED;
            sticky_next = ST_TOOBIG;
          end
        end
      end
      FMT_HDR: begin
        if (seg_done < seg_total) begin
          unique case (phase)
            PH_ADDR: begin
              if (!range_cnt) begin
                range_low_next = b;
                range_cnt_next = 1'b1;
              end else begin
                range_cnt_next = 1'b0;
                if (hi <= {1'b0, lo} || lo < BUS_MIN) begin
                  fmt_next = FMT_REJECTED;
                end else if (({1'b0, wp} + {1'b0, words}) > {1'b0, cap}) begin
                  fmt_next = FMT_REJECTED;
                  sticky_next = ST_TOOBIG;
                end else begin
                  if (maps < MAP_LIMIT) begin
                    res.seg_valid = 1'b1;
                    res.seg_bus_addr = lo;
                    res.seg_stage_start = wp[15:0];
                    res.seg_words = words[15:0];
                    maps_next = maps + MAP_CNT_W'(1);
                  end else begin
                    sticky_next = ST_TRUNC;
                  end
                  seg_addr_next = wp;
                  wp_next = wp + words;
                  words_rem_next = words[15:0];
                  held_flag_next = 1'b0;
                  phase_next = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              if (!held_flag) begin
                held_byte_next = b;
                held_flag_next = 1'b1;
              end else begin
                res.write_valid = 1'b1;
                res.write_addr = seg_addr[15:0];
                res.write_data = {held_byte, b};
                seg_addr_next = seg_addr + 17'd1;
                held_flag_next = 1'b0;
                if (words_rem > 16'd1) begin
                  words_rem_next = words_rem - 16'd1;
                end else begin
                  words_rem_next = 16'd0;
                  phase_next = PH_CRC;
                  crc_cnt_next = 1'b0;
                end
              end
            end
            PH_CRC: begin
              if (!crc_cnt) begin
                crc_cnt_next = 1'b1;
              end else begin
                crc_cnt_next = 1'b0;
                seg_done_next = seg_done + 8'd1;
                phase_next = PH_ADDR;
                range_cnt_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FMT_REJECTED: begin
      end
      default: begin
      end
    endcase

    if (item.last_byte) begin
      res.done_res = 1'b1;
      if (fmt_next == FMT_UNKNOWN || fmt_next == FMT_REJECTED) begin
        res.status = (sticky_next != ST_OK) ? sticky_next : ST_REJECTED;
      end else if (cfg.expected_bytes != '0 && byte_total_next != cfg.expected_bytes) begin
        res.status = ST_TRUNC;
      end else if (fmt_next == FMT_HDR &&
                   (seg_done_next != seg_total_next || maps_next == '0)) begin
        res.status = ST_TRUNC;
      end else begin
        res.status = sticky_next;
      end

      fmt_next = FMT_UNKNOWN;
      phase_next = PH_ADDR;
      sticky_next = ST_OK;
      probe_count_next = 2'd0;
      seg_total_next = 8'h00;
      seg_done_next = 8'h00;
      range_low_next = 8'h00;
      range_cnt_next = 1'b0;
      words_rem_next = 16'd0;
      seg_addr_next = 17'd0;
      held_flag_next = 1'b0;
      held_byte_next = 8'h00;
      crc_cnt_next = 1'b0;
      wp_next = {1'b0, cfg.stage_base};
      byte_total_next = 18'd0;
      maps_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_UNKNOWN;
      phase <= PH_ADDR;
      sticky <= ST_OK;
      probe_count <= 2'd0;
      seg_total <= 8'h00;
      seg_done <= 8'h00;
      range_low <= 8'h00;
      range_cnt <= 1'b0;
      words_rem <= 16'd0;
      seg_addr <= 17'd0;
      held_flag <= 1'b0;
      held_byte <= 8'h00;
      crc_cnt <= 1'b0;
      wp <= {1'b0, cfg.stage_base};
      byte_total <= 18'd0;
      maps <= '0;
    end else if (fire) begin
      fmt <= fmt_next;
      phase <= phase_next;
      sticky <= sticky_next;
      probe_count <= probe_count_next;
      seg_total <= seg_total_next;
      seg_done <= seg_done_next;
      range_low <= range_low_next;
      range_cnt <= range_cnt_next;
      words_rem <= words_rem_next;
      seg_addr <= seg_addr_next;
      held_flag <= held_flag_next;
      held_byte <= held_byte_next;
      crc_cnt <= crc_cnt_next;
      wp <= wp_next;
      byte_total <= byte_total_next;
      maps <= maps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      probe0 <= probe0_next;
      probe1 <= probe1_next;
    end
  end

endmodule

[sv/cisd_out_stage.sv]
module cisd_out_stage
  import cisd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    out_can,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_q
);

  assign out_can = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

[sv/cartridge_image_stream_decoder_unit.sv]
// Cartridge image stream decoder.
// Bytes of one image arrive on the input channel (in_valid, in_ready, data_byte,
// last_byte); the byte with last_byte set closes the stream. Every accepted byte
// gives exactly one result on the output channel (out_valid, out_ready): a store
// write, a segment mapping, or neither, and on the last byte done_res with status.
// An accepted byte is held in an input register, decoded once the output register
// can take its result, and its result lands in the output register. One byte per
// cycle is sustained while out_ready stays high; the per-byte decode of the
// segment and probe state is the only work between the two registers.
// When the receiver stalls, the output register holds its result and the input
// register takes one more byte; then in_ready falls until out_ready returns.
// Reset clears both registers and the decode state and loads the register defaults:
// stage base zero, full store capacity, unknown stream length. The configuration
// port writes a register at each clock edge with cfg_write high and should only be
// used while no request is in flight.
`include "cartridge_image_stream_decoder_unit_macros.svh"

module cartridge_image_stream_decoder_unit
  import cisd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  write_valid,
  output logic [15:0]           write_addr,
  output logic [15:0]           write_data,
  output logic                  seg_valid,
  output logic [15:0]           seg_bus_addr,
  output logic [15:0]           seg_stage_start,
  output logic [15:0]           seg_words,
  output logic                  done_res,
  output logic [1:0]            status,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  logic     out_can;
  logic     fire;
  result_t  res;
  result_t  res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stage_base <= STAGE_BASE_RST;
      cfg.store_words <= STORE_WORDS_RST;
      cfg.expected_bytes <= EXPECTED_BYTES_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STAGE_BASE: cfg.stage_base <= cfg_data[15:0];
        REG_STORE_WORDS: cfg.store_words <= cfg_data[16:0];
        REG_EXPECTED_BYTES: cfg.expected_bytes <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

  assign fire = item_valid && out_can;

  cisd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  cisd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  cisd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .out_can   (out_can),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign write_valid = res_q.write_valid;
  assign write_addr = res_q.write_addr;
  assign write_data = res_q.write_data;
  assign seg_valid = res_q.seg_valid;
  assign seg_bus_addr = res_q.seg_bus_addr;
  assign seg_stage_start = res_q.seg_stage_start;
  assign seg_words = res_q.seg_words;
  assign done_res = res_q.done_res;
  assign status = res_q.status;

  `CISD_ASSERT_NOW(a_single_kind, out_valid, !(write_valid && seg_valid), "write and mapping in one result")
  `CISD_ASSERT_NOW(a_status_only_done, out_valid && !done_res, status == ST_OK, "status without done")
  `CISD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `CISD_ASSERT_NEXT(a_fire_loads, fire, out_valid, "decoded request did not reach output")

endmodule

[tb/cartridge_image_stream_decoder_unit_test.sv]
`timescale 1ns / 1ps

module cartridge_image_stream_decoder_unit_test;
  import cisd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1100;
  localparam int QUIET_BYTES = 300;
  localparam int LONG_STALL = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] data_byte;
  logic last_byte;
  logic out_valid;
  logic out_ready;
  logic write_valid;
  logic [15:0] write_addr;
  logic [15:0] write_data;
  logic seg_valid;
  logic [15:0] seg_bus_addr;
  logic [15:0] seg_stage_start;
  logic [15:0] seg_words;
  logic done_res;
  logic [1:0] status;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cartridge_image_stream_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .write_valid(write_valid),
    .write_addr(write_addr),
    .write_data(write_data),
    .seg_valid(seg_valid),
    .seg_bus_addr(seg_bus_addr),
    .seg_stage_start(seg_stage_start),
    .seg_words(seg_words),
    .done_res(done_res),
    .status(status),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [15:0] cfg_base;
  logic [16:0] cfg_store;
  logic [17:0] cfg_expect;

  fmt_t fmt;
  logic [7:0] probe [3];
  int unsigned probe_n;
  phase_t phase;
  logic [7:0] segs_total;
  logic [7:0] segs_done;
  logic [7:0] page_lo;
  logic page_half;
  logic [16:0] words_left;
  logic [16:0] seg_ptr;
  logic hi_held;
  logic [7:0] hi_byte;
  logic [1:0] crc_n;
  logic [16:0] stage_ptr;
  logic [17:0] byte_cnt;
  int unsigned maps_n;
  status_t err_code;

  result_t nxt;
  result_t oldest;
  result_t outcome_q [$];
  logic [7:0] image_q [$];

  int fail_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int idle_pct = 12;
  int stall_asked = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned cap_words();
    int unsigned c;
    c = cfg_store;
    if (c > STORE_WORDS_MAX) c = STORE_WORDS_MAX;
    if (c > 32'h10000) c = 32'h10000;
    return c;
  endfunction

  task automatic restart_state();
    fmt = FMT_UNKNOWN;
    probe[0] = '0;
    probe[1] = '0;
    probe[2] = '0;
    probe_n = 0;
    phase = PH_ADDR;
    segs_total = '0;
    segs_done = '0;
    page_lo = '0;
    page_half = 1'b0;
    words_left = '0;
    seg_ptr = '0;
    hi_held = 1'b0;
    hi_byte = '0;
    crc_n = '0;
    stage_ptr = {1'b0, cfg_base};
    byte_cnt = '0;
    maps_n = 0;
    err_code = ST_OK;
  endtask

  task automatic mark_rejected(input status_t err);
    fmt = FMT_REJECTED;
    if (err != ST_OK) err_code = err;
  endtask

  task automatic take_flat(input logic [7:0] b);
    if (!hi_held) begin
      hi_byte = b;
      hi_held = 1'b1;
    end else begin
      if (32'(stage_ptr) < cap_words()) begin
        nxt.write_valid = 1'b1;
        nxt.write_addr = stage_ptr[15:0];
        nxt.write_data = {hi_byte, b};
        stage_ptr = stage_ptr + 17'd1;
      end else begin
        mark_rejected(ST_TOOBIG);
      end
      hi_held = 1'b0;
    end
  endtask

  task automatic open_segment(input int unsigned lo, input int unsigned words);
    if (32'(stage_ptr) + words > cap_words()) begin
      mark_rejected(ST_TOOBIG);
    end else begin
      if (maps_n < MAX_MAPPINGS) begin
        nxt.seg_valid = 1'b1;
        nxt.seg_bus_addr = 16'(lo);
        nxt.seg_stage_start = stage_ptr[15:0];
        nxt.seg_words = 16'(words);
        maps_n++;
      end else begin
        err_code = ST_TRUNC;
      end
      seg_ptr = stage_ptr;
      stage_ptr = 17'(32'(stage_ptr) + words);
    end
  endtask

  task automatic take_header(input logic [7:0] b);
    int unsigned lo;
    int unsigned hi;
    if (segs_done < segs_total) begin
      case (phase)
        PH_ADDR: begin
          if (!page_half) begin
            page_lo = b;
            page_half = 1'b1;
          end else begin
            page_half = 1'b0;
            lo = 32'(page_lo) * 256;
            hi = 32'(b) * 256 + 32'(PAGE_WORDS);
            if (hi <= lo || lo < 32'(BUS_MIN) || hi > 32'h10000) begin
              mark_rejected(ST_OK);
            end else begin
              open_segment(lo, hi - lo);
              if (fmt != FMT_REJECTED) begin
                words_left = 17'(hi - lo);
                hi_held = 1'b0;
                phase = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          if (!hi_held) begin
            hi_byte = b;
            hi_held = 1'b1;
          end else begin
            nxt.write_valid = 1'b1;
            nxt.write_addr = seg_ptr[15:0];
            nxt.write_data = {hi_byte, b};
            seg_ptr = seg_ptr + 17'd1;
            hi_held = 1'b0;
            if (words_left > 0) words_left = words_left - 17'd1;
            if (words_left == 0) begin
              phase = PH_CRC;
              crc_n = '0;
            end
          end
        end
        default: begin
          crc_n = crc_n + 2'd1;
          if (crc_n >= 2) begin
            crc_n = '0;
            segs_done = segs_done + 8'd1;
            phase = PH_ADDR;
            page_half = 1'b0;
          end
        end
      endcase
    end
  endtask

  task automatic take_probe(input logic [7:0] b);
    probe[probe_n] = b;
    probe_n++;
    if (probe_n == 3) begin
      if ((probe[0] == MAGIC_A || probe[0] == MAGIC_B || probe[0] == MAGIC_C) &&
          probe[1] != 0 && (probe[1] ^ probe[2]) == COMPL_MASK) begin
        fmt = FMT_HDR;
        segs_total = probe[1];
        segs_done = '0;
        phase = PH_ADDR;
        page_half = 1'b0;
        maps_n = 0;
      end else begin
        fmt = FMT_FLAT;
        hi_held = 1'b0;
        if (cfg_expect != 0 && 32'(cfg_base) + 32'(cfg_expect / 2) > cap_words()) begin
          mark_rejected(ST_TOOBIG);
        end else begin
          take_flat(probe[0]);
          take_flat(probe[1]);
          if (fmt == FMT_FLAT) take_flat(probe[2]);
        end
      end
    end
  endtask

  function automatic status_t end_code();
    status_t st;
    st = ST_OK;
    if (fmt == FMT_UNKNOWN || fmt == FMT_REJECTED)
      st = (err_code != ST_OK) ? err_code : ST_REJECTED;
    else if (cfg_expect != 0 && byte_cnt != cfg_expect)
      st = ST_TRUNC;
    else if (fmt == FMT_HDR && (segs_done != segs_total || maps_n == 0))
      st = ST_TRUNC;
    if (st == ST_OK) st = err_code;
    return st;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    nxt = '0;
    if (byte_cnt == 0 && fmt == FMT_UNKNOWN && probe_n == 0) begin
      stage_ptr = {1'b0, cfg_base};
      if (32'(cfg_expect / 2) > cap_words()) mark_rejected(ST_TOOBIG);
    end
    if (byte_cnt != 18'h3FFFF) byte_cnt = byte_cnt + 18'd1;
    case (fmt)
      FMT_UNKNOWN: take_probe(b);
      FMT_FLAT: take_flat(b);
      FMT_HDR: take_header(b);
      default: ;
    endcase
    if (fin) begin
      nxt.done_res = 1'b1;
      nxt.status = end_code();
      restart_state();
    end
  endtask

  // Every accepted request yields exactly one outcome.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      decode_byte(data_byte, last_byte);
      outcome_q.push_back(nxt);
    end
  end

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual write %0h seg %0h done %0h",
                 $time, write_valid, seg_valid, done_res);
        fail_count++;
      end else begin
        oldest = outcome_q.pop_front();
        check_field("write_valid", oldest.write_valid, write_valid);
        check_field("write_addr", oldest.write_addr, write_addr);
        check_field("write_data", oldest.write_data, write_data);
        check_field("seg_valid", oldest.seg_valid, seg_valid);
        check_field("seg_bus_addr", oldest.seg_bus_addr, seg_bus_addr);
        check_field("seg_stage_start", oldest.seg_stage_start, seg_stage_start);
        check_field("seg_words", oldest.seg_words, seg_words);
        check_field("done_res", oldest.done_res, done_res);
        check_field("status", oldest.status, status);
      end
    end
  end

  initial begin
    int stall_seen;
    int stall_left;
    stall_seen = 0;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_seen) begin
        stall_seen = stall_asked;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_image();
    int i;
    for (i = 0; i < image_q.size(); i++) push_byte(image_q[i], i == image_q.size() - 1);
    image_q.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_STAGE_BASE: cfg_base = value[15:0];
      REG_STORE_WORDS: cfg_store = value[16:0];
      REG_EXPECTED_BYTES: cfg_expect = value[17:0];
      default: ;
    endcase
  endtask

  task automatic add_flat(input int n);
    repeat (n) image_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_header(input logic [7:0] magic, input logic [7:0] count);
    image_q.push_back(magic);
    image_q.push_back(count);
    image_q.push_back(~count);
  endtask

  // Data and check bytes follow only when the page range is one the decoder takes.
  task automatic add_segment(input logic [7:0] lo_pg, input logic [7:0] hi_pg);
    image_q.push_back(lo_pg);
    image_q.push_back(hi_pg);
    if (hi_pg >= lo_pg && lo_pg >= BUS_MIN[15:8]) begin
      add_flat((32'(hi_pg) - 32'(lo_pg) + 1) * 512);
      add_flat(2);
    end
  endtask

  function automatic logic [7:0] pick_magic();
    case ($urandom_range(2))
      0: return MAGIC_A;
      1: return MAGIC_B;
      default: return MAGIC_C;
    endcase
  endfunction

  task automatic test_flat_streams();
    image_q = {8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A};
    send_image();
    image_q = {MAGIC_A};
    send_image();
    image_q = {MAGIC_B, 8'h01};
    send_image();
    image_q = {8'h12, 8'h34, 8'h56};
    send_image();
    add_flat(20);
    send_image();
  endtask

  task automatic test_header_formats();
    add_header(MAGIC_A, 8'd1);
    add_segment(8'h20, 8'h20);
    add_flat(4);
    send_image();
    add_header(MAGIC_B, 8'd1);
    add_segment(8'h7F, 8'h7F);
    send_image();
    add_header(MAGIC_C, 8'd1);
    add_segment(8'hFF, 8'hFF);
    send_image();
    image_q = {MAGIC_A, 8'h00, 8'hFF, 8'h11, 8'h22};
    send_image();
    image_q = {MAGIC_B, 8'h05, 8'hFB, 8'h33};
    send_image();
    image_q = {8'h60, 8'h01, 8'hFE, 8'h44};
    send_image();
    add_header(MAGIC_C, 8'd2);
    image_q.push_back(8'h20);
    image_q.push_back(8'h20);
    add_flat(10);
    send_image();
    add_header(MAGIC_A, 8'd1);
    send_image();
  endtask

  task automatic test_page_ranges();
    add_header(MAGIC_A, 8'd1);
    add_segment(8'h30, 8'h2F);
    add_flat(3);
    send_image();
    add_header(MAGIC_B, 8'd1);
    add_segment(8'h1F, 8'h20);
    add_flat(2);
    send_image();
    add_header(MAGIC_C, 8'd1);
    add_segment(8'h00, 8'h00);
    send_image();
    add_header(MAGIC_A, 8'd2);
    add_segment(8'h20, 8'h20);
    add_segment(8'h40, 8'h3F);
    add_flat(2);
    send_image();
  endtask

  task automatic test_capacity();
    drain();
    set_reg(REG_STAGE_BASE, 18'd290);
    set_reg(REG_STORE_WORDS, 18'd300);
    add_flat(30);
    send_image();
    drain();
    set_reg(REG_STAGE_BASE, 18'd100);
    add_header(MAGIC_B, 8'd1);
    image_q.push_back(8'h20);
    image_q.push_back(8'h20);
    add_flat(4);
    send_image();
    drain();
    set_reg(REG_STAGE_BASE, 18'd0);
    set_reg(REG_STORE_WORDS, 18'd0);
    add_flat(6);
    send_image();
    drain();
    set_reg(REG_STORE_WORDS, 18'h1FFFF);
    set_reg(REG_STAGE_BASE, 18'h3FFFF);
    add_flat(8);
    send_image();
    drain();
    set_reg(REG_STORE_WORDS, 18'h10000);
    set_reg(REG_STAGE_BASE, 18'hFF00);
    add_header(MAGIC_C, 8'd1);
    add_segment(8'hE0, 8'hE0);
    send_image();
    drain();
    set_reg(REG_STAGE_BASE, 18'd0);
  endtask

  task automatic test_stream_length();
    drain();
    add_flat(10);
    set_reg(REG_EXPECTED_BYTES, 18'd10);
    send_image();
    add_flat(9);
    send_image();
    drain();
    add_header(MAGIC_C, 8'd1);
    add_segment(8'h80, 8'h80);
    set_reg(REG_EXPECTED_BYTES, 18'(image_q.size()));
    send_image();
    drain();
    set_reg(REG_EXPECTED_BYTES, 18'h3FFFF);
    add_flat(5);
    send_image();
    drain();
    set_reg(REG_STAGE_BASE, 18'd1);
    set_reg(REG_EXPECTED_BYTES, 18'h20000);
    add_flat(6);
    send_image();
    add_header(MAGIC_A, 8'd1);
    add_flat(4);
    send_image();
    drain();
    set_reg(REG_UNUSED, 18'($urandom_range(262143)));
    set_reg(REG_STAGE_BASE, 18'd0);
    set_reg(REG_EXPECTED_BYTES, 18'd0);
  endtask

  task automatic test_map_table_full();
    int s;
    add_header(MAGIC_B, 8'(MAX_MAPPINGS + 1));
    for (s = 0; s <= MAX_MAPPINGS; s++) add_segment(8'(8'h20 + s), 8'(8'h20 + s));
    send_image();
  endtask

  task automatic test_back_pressure();
    drain();
    idle_pct = 0;
    stall_asked++;
    add_flat(64);
    send_image();
    drain();
    idle_pct = 12;
  endtask

  task automatic test_random_streams();
    int start;
    int kind;
    int nseg;
    int s;
    int lo;
    int hi;
    int keep;
    start = bytes_sent;
    idle_pct = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start >= QUIET_BYTES) idle_pct = 12;
      kind = $urandom_range(99);
      if (kind < 40) begin
        nseg = ($urandom_range(3) == 0) ? 2 : 1;
        add_header(pick_magic(), 8'(nseg + (($urandom_range(4) == 0) ? 1 : 0)));
        for (s = 0; s < nseg; s++) begin
          lo = $urandom_range(8'hFF, 8'h20);
          hi = (lo < 8'hFF && $urandom_range(7) == 0) ? lo + 1 : lo;
          add_segment(8'(lo), 8'(hi));
        end
        if ($urandom_range(4) == 0) begin
          keep = $urandom_range(image_q.size(), 1);
          while (image_q.size() > keep) void'(image_q.pop_back());
        end else if ($urandom_range(4) == 0) begin
          add_flat($urandom_range(5, 1));
        end
      end else if (kind < 75) begin
        add_flat($urandom_range(48, 1));
      end else begin
        case ($urandom_range(3))
          0: begin
            add_header(pick_magic(), 8'($urandom_range(255, 1)));
            add_segment(8'($urandom_range(8'h1F)), 8'($urandom_range(255)));
          end
          1: begin
            add_header(pick_magic(), 8'($urandom_range(255, 1)));
            lo = $urandom_range(8'hFF, 8'h21);
            add_segment(8'(lo), 8'($urandom_range(lo - 1)));
          end
          2: begin
            image_q.push_back(pick_magic());
            add_flat(2);
          end
          default: add_flat($urandom_range(8, 1));
        endcase
        add_flat($urandom_range(6));
      end
      if ($urandom_range(99) < 15) begin
        drain();
        case ($urandom_range(3))
          0: set_reg(REG_STAGE_BASE, 18'd0);
          1: set_reg(REG_STAGE_BASE, 18'($urandom_range(1023)));
          2: set_reg(REG_STAGE_BASE, 18'($urandom_range(262143)));
          default: set_reg(REG_STAGE_BASE, 18'h0FFFF);
        endcase
        case ($urandom_range(3))
          0: set_reg(REG_STORE_WORDS, 18'h10000);
          1: set_reg(REG_STORE_WORDS, 18'($urandom_range(131071)));
          2: set_reg(REG_STORE_WORDS, 18'($urandom_range(4000, 256)));
          default: set_reg(REG_STORE_WORDS, 18'h1FFFF);
        endcase
        case ($urandom_range(4))
          0, 1: set_reg(REG_EXPECTED_BYTES, 18'd0);
          2: set_reg(REG_EXPECTED_BYTES, 18'(image_q.size()));
          3: set_reg(REG_EXPECTED_BYTES, 18'(image_q.size() + 1));
          default: set_reg(REG_EXPECTED_BYTES, 18'($urandom_range(262143)));
        endcase
      end
      send_image();
    end
    idle_pct = 12;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_base = STAGE_BASE_RST;
    cfg_store = STORE_WORDS_RST;
    cfg_expect = EXPECTED_BYTES_RST;
    restart_state();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_flat_streams();
    test_header_formats();
    test_page_ranges();
    test_capacity();
    test_stream_length();
    test_map_table_full();
    test_back_pressure();
    test_random_streams();
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
